### design/pcx_image_rle_decoder_macros.svh
// Assertion macros used by the checker of the PCX RLE decoder.
`ifndef PCX_IMAGE_RLE_DECODER_MACROS_SVH
`define PCX_IMAGE_RLE_DECODER_MACROS_SVH

// Check that pre implies post in the same cycle, outside reset.
`define PCX_ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pcx rle decoder: same-cycle check failed");

// Check that pre implies post in the next cycle, outside reset.
`define PCX_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pcx rle decoder: next-cycle check failed");

// Check a condition at every edge, reset included.
`define PCX_ASSERT_ALWAYS(name, clk, cond) \
    name: assert property (@(posedge clk) (cond)) \
        else $error("pcx rle decoder: invariant failed");

`endif

### design/pcx_rle_pkg.sv
// Shared types and constants of the PCX RLE decoder.
package pcx_rle_pkg;

    // File format constants
    localparam logic [7:0] PCX_MAGIC        = 8'd10;
    localparam logic [7:0] RUN_MARK         = 8'd192;
    localparam logic [5:0] RUN_COUNT_MASK   = 6'h3F;
    localparam int         HEADER_BYTES     = 128;
    localparam int         HDR_IDX_W        = $clog2(HEADER_BYTES);
    localparam int         CORNER_FIRST     = 4;
    localparam int         CORNER_LAST      = 11;

    // Size arithmetic
    localparam int         DIM_W            = 18;
    localparam int         DIM_MAG_W        = 17;
    localparam int         PROD_W           = 2 * DIM_MAG_W;
    localparam int         TOTAL_MAX_W      = 32;

    // Defaults of the top-level parameters
    localparam int         DEF_PIXEL_COUNT_BITS = 24;
    localparam int         DEF_CMD_DEPTH        = 4;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_BAD_MAGIC = 2'd1,
        KIND_BAD_WIDTH = 2'd2,
        KIND_TOO_LARGE = 2'd3
    } kind_t;

    // Input item
    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } file_item_t;

    // Result item
    typedef struct packed {
        logic [7:0] pixel;
        kind_t      kind;
        logic       last;
    } result_t;

    // Command from front to back
    typedef enum logic [1:0] {
        CMD_IMAGE  = 2'd0,
        CMD_PIXELS = 2'd1,
        CMD_ERROR  = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                  op;
        logic [7:0]               value;
        logic [5:0]               count;
        kind_t                    kind;
        logic [TOTAL_MAX_W-1:0]   total;
    } cmd_t;

endpackage

### design/pcx_image_rle_decoder.sv
// PCX RLE decoder: 8-bit palette images, one file byte in, one pixel out.
// Feed the file byte by byte with start_of_file on its first byte. Header
// bytes are taken one per cycle while the command queue has room, except
// that after header byte 11 the input reports full while the width, height
// and pixel total are formed and checked (subtract, then one 17x17 multiply,
// then the range compare). Data bytes are taken one per cycle while the
// command queue has room; each literal byte yields one pixel and each run
// yields its count of pixels, one per cycle from the back end while results
// are taken, and the result side sets the sustained rate. A pixel passes
// through the command queue, the run registers and the result register
// before it shows up on the result port. Errors (bad magic, bad width, size
// too large) arrive as a single result with last set; then nothing more comes
// out until the next start_of_file. Bytes after the final pixel, the palette
// among them, are dropped.
module pcx_image_rle_decoder #(
    parameter int PIXEL_COUNT_BITS = pcx_rle_pkg::DEF_PIXEL_COUNT_BITS,
    parameter int CMD_DEPTH        = pcx_rle_pkg::DEF_CMD_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  pcx_rle_pkg::file_item_t file_item,
    input  logic                    pop,
    output logic                    empty,
    output pcx_rle_pkg::result_t    result
);
    import pcx_rle_pkg::*;

    logic   cmd_push;
    logic   cmd_full;
    logic   cmd_pop;
    logic   cmd_empty;
    cmd_t   cmd_wdata;
    cmd_t   cmd_rdata;

    // Parse and classify
    pcx_rle_front #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .file_item (file_item),
        .cmd_push  (cmd_push),
        .cmd       (cmd_wdata),
        .cmd_full  (cmd_full)
    );

    // Decouple front and back
    pcx_rle_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    // Expand and emit
    pcx_rle_back #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_rdata),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

### design/pcx_rle_front.sv
// Front end: header parsing, size check and byte classification into commands.
module pcx_rle_front #(
    parameter int PIXEL_COUNT_BITS = pcx_rle_pkg::DEF_PIXEL_COUNT_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  pcx_rle_pkg::file_item_t file_item,
    output logic                    cmd_push,
    output pcx_rle_pkg::cmd_t       cmd,
    input  logic                    cmd_full
);
    import pcx_rle_pkg::*;

    typedef enum logic [5:0] {
        FS_HEADER   = 6'b000001,
        FS_CALC_DIM = 6'b000010,
        FS_CALC_MUL = 6'b000100,
        FS_ISSUE    = 6'b001000,
        FS_DATA     = 6'b010000,
        FS_IDLE     = 6'b100000
    } front_state_t;

    front_state_t               state_reg, state_next;
    logic [HDR_IDX_W-1:0]       idx_reg, idx_next;
    logic [15:0]                corner_reg [4];
    logic [15:0]                corner_next [4];
    logic                       run_pending_reg, run_pending_next;
    logic [5:0]                 run_len_reg, run_len_next;
    logic signed [DIM_W-1:0]    width_reg, width_next;
    logic signed [DIM_W-1:0]    height_reg, height_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;

    logic                       accepting;
    logic                       accept;
    logic [HDR_IDX_W-1:0]       hdr_idx;
    logic [HDR_IDX_W-1:0]       corner_off;
    logic [1:0]                 corner_sel;
    logic [7:0]                 byte_in;

    assign byte_in    = file_item.file_byte;
    assign accepting  = (state_reg == FS_HEADER) || (state_reg == FS_DATA)
                        || (state_reg == FS_IDLE);
    assign full       = !accepting || cmd_full;
    assign accept     = push && !full;
    assign hdr_idx    = file_item.start_of_file ? '0 : idx_reg;
    assign corner_off = hdr_idx - HDR_IDX_W'(CORNER_FIRST);
    assign corner_sel = corner_off[2:1];

    // Next-state logic of the parser
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        corner_next      = corner_reg;
        run_pending_next = run_pending_reg;
        run_len_next     = run_len_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        prod_next        = prod_reg;
        cmd_push         = 1'b0;
        cmd              = '0;

        case (state_reg)
            FS_CALC_DIM:
            begin
                // Form width and height from the corner words
                width_next  = $signed({{2{corner_reg[2][15]}}, corner_reg[2]})
                              - $signed({{2{corner_reg[0][15]}}, corner_reg[0]})
                              + DIM_W'(1);
                height_next = $signed({{2{corner_reg[3][15]}}, corner_reg[3]})
                              - $signed({{2{corner_reg[1][15]}}, corner_reg[1]})
                              + DIM_W'(1);
                state_next  = FS_CALC_MUL;
            end
            FS_CALC_MUL:
            begin
                // Multiply the magnitudes; only used when both are positive
                prod_next  = PROD_W'(width_reg[DIM_MAG_W-1:0])
                             * PROD_W'(height_reg[DIM_MAG_W-1:0]);
                state_next = FS_ISSUE;
            end
            FS_ISSUE:
            begin
                // Issue the image start or the size error
                if (!cmd_full)
                begin
                    cmd_push = 1'b1;
                    if (width_reg <= DIM_W'(1))
                    begin
                        cmd.op     = CMD_ERROR;
                        cmd.kind   = KIND_BAD_WIDTH;
                        state_next = FS_IDLE;
                    end
                    else if ((height_reg <= DIM_W'(0))
                             || ((prod_reg >> PIXEL_COUNT_BITS) != '0))
                    begin
                        cmd.op     = CMD_ERROR;
                        cmd.kind   = KIND_TOO_LARGE;
                        state_next = FS_IDLE;
                    end
                    else
                    begin
                        cmd.op     = CMD_IMAGE;
                        cmd.total  = TOTAL_MAX_W'(prod_reg[PIXEL_COUNT_BITS-1:0]);
                        state_next = FS_HEADER;
                    end
                end
            end
            FS_HEADER, FS_DATA, FS_IDLE:
            begin
                if (accept)
                begin
                    if (file_item.start_of_file || (state_reg == FS_HEADER))
                    begin
                        run_pending_next = 1'b0;
                        if ((hdr_idx == '0) && (byte_in != PCX_MAGIC))
                        begin
                            // Bad magic: report and drop the rest of the file
                            cmd_push   = 1'b1;
                            cmd.op     = CMD_ERROR;
                            cmd.kind   = KIND_BAD_MAGIC;
                            state_next = FS_IDLE;
                        end
                        else
                        begin
                            if ((hdr_idx >= HDR_IDX_W'(CORNER_FIRST))
                                && (hdr_idx <= HDR_IDX_W'(CORNER_LAST)))
                            begin
                                if (corner_off[0])
                                    corner_next[corner_sel][15:8] = byte_in;
                                else
                                    corner_next[corner_sel][7:0] = byte_in;
                            end
                            idx_next = hdr_idx + HDR_IDX_W'(1);
                            if (hdr_idx == HDR_IDX_W'(CORNER_LAST))
                                state_next = FS_CALC_DIM;
                            else if (hdr_idx == HDR_IDX_W'(HEADER_BYTES - 1))
                                state_next = FS_DATA;
                            else
                                state_next = FS_HEADER;
                        end
                    end
                    else if (state_reg == FS_DATA)
                    begin
                        if (run_pending_reg)
                        begin
                            // Run value: drop zero-length runs
                            run_pending_next = 1'b0;
                            if (run_len_reg != '0)
                            begin
                                cmd_push  = 1'b1;
                                cmd.op    = CMD_PIXELS;
                                cmd.value = byte_in;
                                cmd.count = run_len_reg;
                            end
                        end
                        else if (byte_in >= RUN_MARK)
                        begin
                            run_pending_next = 1'b1;
                            run_len_next     = byte_in[5:0] & RUN_COUNT_MASK;
                        end
                        else
                        begin
                            cmd_push  = 1'b1;
                            cmd.op    = CMD_PIXELS;
                            cmd.value = byte_in;
                            cmd.count = 6'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= FS_HEADER;
            idx_reg         <= '0;
            run_pending_reg <= 1'b0;
            run_len_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                corner_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            run_pending_reg <= run_pending_next;
            run_len_reg     <= run_len_next;
            corner_reg      <= corner_next;
        end
    end

    // Size arithmetic registers
    always_ff @(posedge clk)
    begin
        width_reg  <= width_next;
        height_reg <= height_next;
        prod_reg   <= prod_next;
    end

endmodule

### design/pcx_rle_cmd_fifo.sv
// Short command queue between the front and back ends.
module pcx_rle_cmd_fifo #(
    parameter int DEPTH = pcx_rle_pkg::DEF_CMD_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pcx_rle_pkg::cmd_t  wdata,
    output logic               full,
    input  logic               pop,
    output pcx_rle_pkg::cmd_t  rdata,
    output logic               empty
);
    import pcx_rle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t               entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the written entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

### design/pcx_rle_back.sv
// Back end: run expansion, pixel counting and the result register.
module pcx_rle_back #(
    parameter int PIXEL_COUNT_BITS = pcx_rle_pkg::DEF_PIXEL_COUNT_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_empty,
    input  pcx_rle_pkg::cmd_t    cmd,
    output logic                 cmd_pop,
    input  logic                 pop,
    output logic                 empty,
    output pcx_rle_pkg::result_t result
);
    import pcx_rle_pkg::*;

    logic                           active_reg, active_next;
    logic [PIXEL_COUNT_BITS-1:0]    done_reg, done_next;
    logic [PIXEL_COUNT_BITS-1:0]    total_reg, total_next;
    logic [5:0]                     run_left_reg, run_left_next;
    logic [7:0]                     run_value_reg, run_value_next;
    logic                           out_valid_reg, out_valid_next;
    result_t                        out_reg, out_next;

    logic                           slot_free;
    logic [PIXEL_COUNT_BITS:0]      done_sum;
    logic                           last_pixel;

    assign slot_free  = !out_valid_reg || pop;
    assign done_sum   = {1'b0, done_reg} + (PIXEL_COUNT_BITS + 1)'(1);
    assign last_pixel = (done_sum >= {1'b0, total_reg});
    assign empty      = !out_valid_reg;
    assign result     = out_reg;

    // Expand runs and take commands
    always_comb
    begin
        active_next    = active_reg;
        done_next      = done_reg;
        total_next     = total_reg;
        run_left_next  = run_left_reg;
        run_value_next = run_value_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        cmd_pop        = 1'b0;

        if (run_left_reg != '0)
        begin
            // Emit one pixel of the current run
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_next.pixel = run_value_reg;
                out_next.kind  = KIND_PIXEL;
                out_next.last  = last_pixel;
                done_next      = done_sum[PIXEL_COUNT_BITS-1:0];
                if (last_pixel)
                begin
                    run_left_next = '0;
                    active_next   = 1'b0;
                end
                else
                begin
                    run_left_next = run_left_reg - 6'd1;
                end
            end
        end
        else if (!cmd_empty)
        begin
            case (cmd.op)
                CMD_IMAGE:
                begin
                    cmd_pop     = 1'b1;
                    total_next  = cmd.total[PIXEL_COUNT_BITS-1:0];
                    done_next   = '0;
                    active_next = 1'b1;
                end
                CMD_PIXELS:
                begin
                    // Drop pixels past the end of the image
                    cmd_pop = 1'b1;
                    if (active_reg)
                    begin
                        run_left_next  = cmd.count;
                        run_value_next = cmd.value;
                    end
                end
                CMD_ERROR:
                begin
                    if (slot_free)
                    begin
                        cmd_pop        = 1'b1;
                        active_next    = 1'b0;
                        out_valid_next = 1'b1;
                        out_next.pixel = 8'd0;
                        out_next.kind  = cmd.kind;
                        out_next.last  = 1'b1;
                    end
                end
                default:
                begin
                    cmd_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            done_reg      <= '0;
            total_reg     <= '0;
            run_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            done_reg      <= done_next;
            total_reg     <= total_next;
            run_left_reg  <= run_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        run_value_reg <= run_value_next;
        out_reg       <= out_next;
    end

endmodule

### design/pcx_rle_checker.sv
// Port-level checker of the PCX RLE decoder and its bind.
`include "pcx_image_rle_decoder_macros.svh"

module pcx_rle_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    push,
    input logic                    full,
    input pcx_rle_pkg::file_item_t file_item,
    input logic                    pop,
    input logic                    empty,
    input pcx_rle_pkg::result_t    result
);
    import pcx_rle_pkg::*;

    // Reset leaves the input open and the result side empty
    `PCX_ASSERT_ALWAYS(a_reset_idle, clk, rst_n || (empty && !full))

    // A waiting result holds until it is taken
    `PCX_ASSERT_NEXT(a_result_hold, clk, rst_n, !empty && !pop, !empty && $stable(result))

    // An error result carries a zero pixel and closes the image
    `PCX_ASSERT_SAME(a_error_closes, clk, rst_n, !empty && (result.kind != KIND_PIXEL),
        result.last && (result.pixel == 8'd0))

endmodule

bind pcx_image_rle_decoder pcx_rle_checker u_checker (.*);

### tb/sv/pcx_image_rle_decoder_test.sv
// Self-checking testbench for the PCX RLE decoder: byte stream in, pixels checked in order.
`timescale 1ns / 100ps

module pcx_image_rle_decoder_test;

    import pcx_rle_pkg::*;

    localparam int COUNT_BITS = DEF_PIXEL_COUNT_BITS;

    // Track decoder state per byte and hold the pixels it must produce
    class pixel_scoreboard;
        typedef enum {PARSE_HEADER, PARSE_DATA, PARSE_DONE} parse_stage_t;

        parse_stage_t stage;
        int           header_pos;
        logic [15:0]  corner [4];
        bit           run_armed;
        int           run_count;
        longint       pixels_out;
        longint       pixel_total;
        result_t      expected_pixels [$];
        int           errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            stage = PARSE_HEADER;
            header_pos = 0;
            foreach (corner[i]) corner[i] = '0;
            run_armed = 0;
            run_count = 0;
            pixels_out = 0;
            pixel_total = 0;
        endfunction

        function void add_result(logic [7:0] value, kind_t kind, logic last);
            result_t r;
            r.pixel = value;
            r.kind = kind;
            r.last = last;
            expected_pixels.push_back(r);
        endfunction

        function void fail_file(kind_t kind);
            add_result(8'h00, kind, 1'b1);
            stage = PARSE_DONE;
        endfunction

        function void emit_pixel(logic [7:0] value);
            pixels_out++;
            if (pixels_out >= pixel_total) begin
                add_result(value, KIND_PIXEL, 1'b1);
                stage = PARSE_DONE;
            end
            else
                add_result(value, KIND_PIXEL, 1'b0);
        endfunction

        // Note one accepted byte and predict the pixels it releases
        function void decode_byte(file_item_t it);
            logic [7:0] b;
            int         w;
            int         lo;
            int         hi;
            int         width;
            int         height;
            longint     total;
            b = it.file_byte;
            if (it.start_of_file)
                clear();
            if (stage == PARSE_HEADER) begin
                if (header_pos == 0 && b != PCX_MAGIC) begin
                    fail_file(KIND_BAD_MAGIC);
                    return;
                end
                if (header_pos >= CORNER_FIRST && header_pos <= CORNER_LAST) begin
                    w = (header_pos - CORNER_FIRST) / 2;
                    if (header_pos % 2 == 0)
                        corner[w][7:0] = b;
                    else
                        corner[w][15:8] = b;
                end
                if (header_pos == CORNER_LAST) begin
                    lo = $signed(corner[0]);
                    hi = $signed(corner[2]);
                    width = hi - lo + 1;
                    lo = $signed(corner[1]);
                    hi = $signed(corner[3]);
                    height = hi - lo + 1;
                    if (width <= 1) begin
                        fail_file(KIND_BAD_WIDTH);
                        return;
                    end
                    if (height <= 0) begin
                        fail_file(KIND_TOO_LARGE);
                        return;
                    end
                    total = longint'(width) * longint'(height);
                    if (total >= (longint'(1) << COUNT_BITS)) begin
                        fail_file(KIND_TOO_LARGE);
                        return;
                    end
                    pixel_total = total;
                end
                if (header_pos + 1 >= HEADER_BYTES)
                    stage = PARSE_DATA;
                else
                    header_pos++;
                return;
            end
            if (stage != PARSE_DATA)
                return;
            // Second byte of a run carries the value
            if (run_armed) begin
                run_armed = 0;
                for (int i = 0; i < run_count && stage == PARSE_DATA; i++)
                    emit_pixel(b);
                run_count = 0;
                return;
            end
            if (b >= RUN_MARK) begin
                run_armed = 1;
                run_count = b & RUN_COUNT_MASK;
                return;
            end
            emit_pixel(b);
        endfunction

        // Compare one popped result with the oldest prediction
        function void check_result(result_t got);
            result_t want;
            if (expected_pixels.size() == 0) begin
                $error("result: none expected, got pixel %0d kind %0d last %0d",
                       got.pixel, got.kind, got.last);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel !== want.pixel) begin
                $error("pixel: expected %0d, got %0d", want.pixel, got.pixel);
                errors++;
            end
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b1;
    logic       push = 1'b0;
    logic       full;
    file_item_t file_item = '0;
    logic       pop = 1'b0;
    logic       empty;
    result_t    result;

    pixel_scoreboard sb = new();
    int items_sent = 0;
    int send_idle_pct = 22;
    int take_idle_pct = 49;

    pcx_image_rle_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .file_item (file_item),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic file_item_t make_item(logic [7:0] b, logic sof);
        file_item_t it;
        it.file_byte = b;
        it.start_of_file = sof;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input file_item_t it);
        if (items_sent < 90) begin
            send_idle_pct = 22;
            take_idle_pct = 49;
        end
        else if (items_sent < 180) begin
            send_idle_pct = 49;
            take_idle_pct = 22;
        end
        else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        file_item <= it;
        do @(posedge clk); while (full);
        items_sent++;
        sb.decode_byte(it);
    endtask

    // Send header bytes up to n_bytes, corners in file order
    task automatic send_file_header(input int min_x, input int min_y, input int max_x,
                                    input int max_y, input int n_bytes);
        logic [15:0] corner [4];
        logic [15:0] word;
        file_item_t  it;
        corner[0] = 16'(min_x);
        corner[1] = 16'(min_y);
        corner[2] = 16'(max_x);
        corner[3] = 16'(max_y);
        for (int i = 0; i < n_bytes; i++) begin
            it.start_of_file = (i == 0);
            if (i == 0)
                it.file_byte = PCX_MAGIC;
            else if (i >= CORNER_FIRST && i <= CORNER_LAST) begin
                word = corner[(i - CORNER_FIRST) / 2];
                it.file_byte = (i % 2 == 0) ? word[7:0] : word[15:8];
            end
            else
                it.file_byte = 8'($urandom);
            send_item(it);
        end
    endtask

    // Send literals and runs until the pixel total is covered or max_bytes is reached, then up to three stray bytes
    task automatic send_pixel_data(input longint total, input int max_bytes);
        longint left;
        int     data_bytes;
        int     pick;
        int     run;
        left = total;
        data_bytes = 0;
        while (left > 0 && data_bytes < max_bytes) begin
            pick = $urandom_range(7);
            if (pick < 3) begin
                send_item(make_item(8'($urandom_range(191)), 1'b0));
                left--;
                data_bytes++;
            end
            else begin
                if (pick == 3)
                    run = 0;
                else if (pick < 6)
                    run = $urandom_range(1, 8);
                else
                    run = $urandom_range(1, 63);
                send_item(make_item(RUN_MARK | 8'(run), 1'b0));
                send_item(make_item(8'($urandom), 1'b0));
                left -= run;
                data_bytes += 2;
            end
        end
        repeat ($urandom_range(3)) send_item(make_item(8'($urandom), 1'b0));
    endtask

    // Pop results at random and check each one taken
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(result);
            pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    initial begin
        int         pick;
        int         w;
        int         h;
        int         min_x;
        int         min_y;
        int         max_x;
        int         max_y;
        logic [7:0] b;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bad magic straight after reset, ignored byte, width and size extremes
        send_item(make_item(8'h00, 1'b0));
        send_item(make_item(PCX_MAGIC, 1'b0));
        send_file_header(32767, 0, -32768, 0, 12);
        send_file_header(-32768, -32768, 32767, 32767, 12);

        // Random files: mostly well-formed images, some errors and noise
        while (items_sent < 270) begin
            pick = $urandom_range(9);
            case (pick)
                0: begin
                    repeat ($urandom_range(1, 4))
                        send_item(make_item(8'($urandom), $urandom_range(3) == 0));
                end
                1: begin
                    do b = 8'($urandom); while (b == PCX_MAGIC);
                    send_item(make_item(b, 1'b1));
                    repeat ($urandom_range(2)) send_item(make_item(8'($urandom), 1'b0));
                end
                2: begin
                    case ($urandom_range(2))
                        0: begin
                            min_x = int'($urandom_range(0, 65535)) - 32768;
                            max_x = int'($urandom_range(0, min_x + 32768)) - 32768;
                            min_y = int'($urandom_range(0, 65535)) - 32768;
                            max_y = int'($urandom_range(0, 65535)) - 32768;
                        end
                        1: begin
                            min_x = int'($urandom_range(0, 65534)) - 32768;
                            max_x = int'($urandom_range(min_x + 32769, 65535)) - 32768;
                            min_y = int'($urandom_range(1, 65535)) - 32768;
                            max_y = int'($urandom_range(0, min_y + 32767)) - 32768;
                        end
                        default: begin
                            min_x = -int'($urandom_range(1, 32768));
                            max_x = int'($urandom_range(0, 32767));
                            min_y = int'($urandom_range(0, 100)) - 32768;
                            max_y = 32767 - int'($urandom_range(0, 100));
                        end
                    endcase
                    send_file_header(min_x, min_y, max_x, max_y, 12 + $urandom_range(2));
                end
                3: begin
                    // Legal but huge: decode a few bytes, then leave it unfinished
                    h = $urandom_range(1, 255);
                    min_y = int'($urandom_range(0, 65536 - h)) - 32768;
                    send_file_header(-32768, min_y, 32767, min_y + h - 1, HEADER_BYTES);
                    send_pixel_data(longint'(65536) * h, 8);
                end
                default: begin
                    w = $urandom_range(2, 40);
                    h = $urandom_range(1, 3);
                    min_x = int'($urandom_range(0, 65536 - w)) - 32768;
                    min_y = int'($urandom_range(0, 65536 - h)) - 32768;
                    send_file_header(min_x, min_y, min_x + w - 1, min_y + h - 1,
                                     HEADER_BYTES);
                    send_pixel_data(w * h, 1000);
                end
            endcase
        end
        push <= 1'b0;

        // Drain, then allow stray results to show up
        while (sb.expected_pixels.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/pcx_rle_pkg.sv
design/pcx_rle_front.sv
design/pcx_rle_cmd_fifo.sv
design/pcx_rle_back.sv
design/pcx_image_rle_decoder.sv
design/pcx_rle_checker.sv
tb/sv/pcx_image_rle_decoder_test.sv
